@@ hdl/lers_pkg.sv @@
// Shared types, constants and helpers of the local event repeat scheduler.
package lers_pkg;

  localparam int unsigned MaxLanes      = 4;
  localparam int unsigned DefNumSensors = 4;
  localparam int unsigned SensorW       = 4;
  localparam int unsigned IdxW          = 2;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned SeqW          = 32;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned ItemQDepth    = 2;
  localparam int unsigned ResQDepth     = 4;

  localparam logic [SensorW-1:0] SensorMask = 4'hF;

  localparam logic [7:0]       RstRepeatCount   = 8'd3;
  localparam logic [15:0]      RstRepeatSpacing = 16'd100;
  localparam logic [TimeW-1:0] RstRefreshPeriod = 32'd10000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REPEAT_COUNT,
    REG_REPEAT_SPACING,
    REG_REFRESH_PERIOD
  } cfg_reg_e;

  typedef enum logic {
    KIND_UPDATE,
    KIND_LINK_DROP
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TRANS,
    BK_REFRESH,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [7:0]       repeat_count;
    logic [15:0]      repeat_spacing;
    logic [TimeW-1:0] refresh_period;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [TimeW-1:0]   now_ms;
    logic [SensorW-1:0] bits;
    logic               ready;
    logic [SensorW-1:0] change;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0] sensor_index;
    logic            level;
    logic [SeqW-1:0] sequence_res;
    logic            last;
  } result_t;

  // A deadline is due once the wrapped difference to it is zero or positive.
  function automatic logic is_due(logic [TimeW-1:0] now_ms, logic [TimeW-1:0] deadline);
    logic [TimeW-1:0] diff;
    diff = now_ms - deadline;
    return ~diff[TimeW-1];
  endfunction

endpackage

@@ hdl/lers_fifo.sv @@
// First-word-fall-through queue used for items and for results.
module lers_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == (PtrW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/lers_front.sv @@
// Front end: accepts update and link-drop beats, tracks previous sensor bits and queues classified items.
module lers_front import lers_pkg::*; #(
  parameter int unsigned NUM_SENSORS = DefNumSensors
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               kind_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic [SensorW-1:0] sensor_bits_i,
  input  logic               link_ready_i,
  output item_t              item_o,
  output logic               item_vld_o,
  input  logic               item_pop_i
);

  localparam int unsigned LaneCnt = (NUM_SENSORS < MaxLanes) ? NUM_SENSORS : MaxLanes;
  localparam logic [SensorW-1:0] LaneMask = SensorW'((1 << LaneCnt) - 1);

  logic [SensorW-1:0] prev_bits_q, prev_bits_d;
  logic [SensorW-1:0] bits;
  logic               accept;
  logic               q_empty;
  item_t              item_in;

  assign bits   = sensor_bits_i & SensorMask & LaneMask;
  assign accept = push_i && !full_o;

  always_comb begin
    item_in.kind   = kind_e'(kind_i);
    item_in.now_ms = now_ms_i;
    item_in.bits   = bits;
    item_in.ready  = link_ready_i;
    item_in.change = bits ^ prev_bits_q;
    prev_bits_d    = prev_bits_q;
    if (accept && (kind_e'(kind_i) == KIND_UPDATE)) begin
      prev_bits_d = bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_bits_q <= '0;
    end else begin
      prev_bits_q <= prev_bits_d;
    end
  end

  lers_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(ItemQDepth)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push_i),
    .wdata_i(item_in),
    .full_o (full_o),
    .rd_i   (item_pop_i),
    .rdata_o(item_o),
    .empty_o(q_empty)
  );

  assign item_vld_o = !q_empty;

endmodule

@@ hdl/lers_back.sv @@
// Back end: steps through the sensors of one item and emits announcement beats.
module lers_back import lers_pkg::*; #(
  parameter int unsigned NUM_SENSORS = DefNumSensors
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    item_vld_i,
  output logic    item_pop_o,
  output result_t res_o,
  output logic    res_push_o,
  input  logic    res_full_i
);

  localparam int unsigned LaneCnt = (NUM_SENSORS < MaxLanes) ? NUM_SENSORS : MaxLanes;
  localparam logic [IdxW-1:0] LastLane = IdxW'(LaneCnt - 1);

  back_state_e state_q, state_d;
  logic [IdxW-1:0]  lane_q, lane_d;
  result_t          hold_q, hold_d;
  logic             hold_vld_q, hold_vld_d;
  logic [TimeW-1:0] ref_dl_q;
  logic             ref_dl_en;

  logic [SeqW-1:0]  seq_q      [MaxLanes];
  logic             pend_q     [MaxLanes];
  logic [7:0]       rep_left_q [MaxLanes];
  logic [TimeW-1:0] next_rep_q [MaxLanes];
  logic [TimeW-1:0] last_ref_q [MaxLanes];
  logic             act_sent_q [MaxLanes];

  logic             act, chg;
  logic             emit, emit_lvl, stall;
  logic [SeqW-1:0]  emit_seq;
  logic             wr_chg, wr_rep, wr_ref, clr_all;
  logic [TimeW-1:0] next_time;
  logic [7:0]       rep_init;

  assign act       = item_i.bits[lane_q];
  assign chg       = item_i.change[lane_q];
  assign next_time = item_i.now_ms + TimeW'(cfg_i.repeat_spacing);
  assign rep_init  = (cfg_i.repeat_count != '0) ? cfg_i.repeat_count - 8'd1 : '0;

  always_comb begin
    state_d    = state_q;
    lane_d     = lane_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    item_pop_o = 1'b0;
    res_o      = hold_q;
    res_push_o = 1'b0;
    emit       = 1'b0;
    emit_lvl   = 1'b0;
    emit_seq   = seq_q[lane_q];
    stall      = 1'b0;
    wr_chg     = 1'b0;
    wr_rep     = 1'b0;
    wr_ref     = 1'b0;
    clr_all    = 1'b0;
    ref_dl_en  = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (item_vld_i) begin
          if (item_i.kind == KIND_LINK_DROP) begin
            clr_all    = 1'b1;
            item_pop_o = 1'b1;
          end else if (!item_i.ready) begin
            item_pop_o = 1'b1;
          end else begin
            lane_d  = '0;
            state_d = BK_TRANS;
          end
        end
      end
      BK_TRANS: begin
        if (chg) begin
          emit     = 1'b1;
          emit_lvl = act;
          emit_seq = seq_q[lane_q] + 1'b1;
        end else if ((rep_left_q[lane_q] != '0) &&
                     is_due(item_i.now_ms, next_rep_q[lane_q])) begin
          emit     = 1'b1;
          emit_lvl = pend_q[lane_q];
        end
        stall = emit && hold_vld_q && res_full_i;
        if (!stall) begin
          wr_chg    = chg;
          wr_rep    = emit && !chg;
          ref_dl_en = 1'b1;
          if (!chg) begin
            state_d = BK_REFRESH;
          end else if (lane_q == LastLane) begin
            state_d = BK_DONE;
          end else begin
            lane_d = lane_q + 1'b1;
          end
        end
      end
      BK_REFRESH: begin
        if (act && (!act_sent_q[lane_q] || is_due(item_i.now_ms, ref_dl_q))) begin
          emit     = 1'b1;
          emit_lvl = 1'b1;
          emit_seq = seq_q[lane_q] + 1'b1;
        end
        stall = emit && hold_vld_q && res_full_i;
        if (!stall) begin
          wr_ref = emit;
          if (lane_q == LastLane) begin
            state_d = BK_DONE;
          end else begin
            lane_d  = lane_q + 1'b1;
            state_d = BK_TRANS;
          end
        end
      end
      BK_DONE: begin
        if (!hold_vld_q) begin
          item_pop_o = 1'b1;
          state_d    = BK_IDLE;
        end else if (!res_full_i) begin
          res_o.last = 1'b1;
          res_push_o = 1'b1;
          hold_vld_d = 1'b0;
          item_pop_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (emit && !stall) begin
      if (hold_vld_q) begin
        res_o.last = 1'b0;
        res_push_o = 1'b1;
      end
      hold_d.sensor_index = lane_q;
      hold_d.level        = emit_lvl;
      hold_d.sequence_res = emit_seq;
      hold_d.last         = 1'b0;
      hold_vld_d          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      lane_q     <= '0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      lane_q     <= lane_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (ref_dl_en) begin
      ref_dl_q <= last_ref_q[lane_q] + cfg_i.refresh_period;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLanes; i++) begin
        seq_q[i]      <= '0;
        pend_q[i]     <= 1'b0;
        rep_left_q[i] <= '0;
        next_rep_q[i] <= '0;
        last_ref_q[i] <= '0;
        act_sent_q[i] <= 1'b0;
      end
    end else begin
      if (clr_all) begin
        for (int i = 0; i < MaxLanes; i++) begin
          rep_left_q[i] <= '0;
          act_sent_q[i] <= 1'b0;
        end
      end
      if (wr_chg) begin
        seq_q[lane_q]      <= emit_seq;
        pend_q[lane_q]     <= act;
        rep_left_q[lane_q] <= rep_init;
        next_rep_q[lane_q] <= next_time;
        act_sent_q[lane_q] <= act;
        if (act) begin
          last_ref_q[lane_q] <= item_i.now_ms;
        end
      end
      if (wr_rep) begin
        rep_left_q[lane_q] <= rep_left_q[lane_q] - 8'd1;
        next_rep_q[lane_q] <= next_time;
      end
      if (wr_ref) begin
        seq_q[lane_q]      <= emit_seq;
        last_ref_q[lane_q] <= item_i.now_ms;
        act_sent_q[lane_q] <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/local_event_repeat_scheduler_top.sv @@
// Top level of the local event repeat scheduler: configuration registers and result queue.
// Results: a result waits in a holding register for the next one or the end of the walk.
// Walk: a ready update visits each sensor in a transition step and, unless the sensor changed,
// a refresh step, then a done step; other beats are popped in idle; a full result queue stalls.
// Reset: asynchronous, active low; clears all sensor state, queues and restores default config.
module local_event_repeat_scheduler_top import lers_pkg::*; #(
  parameter int unsigned NUM_SENSORS = DefNumSensors
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                kind_i,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic [SensorW-1:0]  sensor_bits_i,
  input  logic                link_ready_i,
  output logic                empty,
  input  logic                pop,
  output logic [IdxW-1:0]     sensor_index_o,
  output logic                level_o,
  output logic [SeqW-1:0]     sequence_res_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item;
  logic    item_vld, item_pop;
  result_t res, res_head;
  logic    res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_count   <= RstRepeatCount;
      cfg_q.repeat_spacing <= RstRepeatSpacing;
      cfg_q.refresh_period <= RstRefreshPeriod;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_REPEAT_COUNT:   cfg_q.repeat_count   <= cfg_data_i[7:0];
        REG_REPEAT_SPACING: cfg_q.repeat_spacing <= cfg_data_i[15:0];
        REG_REFRESH_PERIOD: cfg_q.refresh_period <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  lers_front #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .now_ms_i     (now_ms_i),
    .sensor_bits_i(sensor_bits_i),
    .link_ready_i (link_ready_i),
    .item_o       (item),
    .item_vld_o   (item_vld),
    .item_pop_i   (item_pop)
  );

  lers_back #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .item_i    (item),
    .item_vld_i(item_vld),
    .item_pop_o(item_pop),
    .res_o     (res),
    .res_push_o(res_push),
    .res_full_i(res_full)
  );

  lers_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(ResQDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .rd_i   (pop),
    .rdata_o(res_head),
    .empty_o(empty)
  );

  assign sensor_index_o = res_head.sensor_index;
  assign level_o        = res_head.level;
  assign sequence_res_o = res_head.sequence_res;
  assign last_o         = res_head.last;

endmodule

@@ hdl/lers_checker.sv @@
// Port-level checker of the local event repeat scheduler, bound to the top level.
module lers_checker import lers_pkg::*; #(
  parameter int unsigned NUM_SENSORS = DefNumSensors
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input logic [IdxW-1:0]     sensor_index_o,
  input logic                level_o,
  input logic [SeqW-1:0]     sequence_res_o,
  input logic                last_o
);

  localparam int unsigned LaneCnt = (NUM_SENSORS < MaxLanes) ? NUM_SENSORS : MaxLanes;

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (sensor_index_o <= IdxW'(LaneCnt - 1)))
    else $error("announcement for a sensor that is not handled");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(sequence_res_o) && $stable(sensor_index_o)
                          && $stable(level_o) && $stable(last_o)))
    else $error("waiting result beat changed");

endmodule

bind local_event_repeat_scheduler_top lers_checker #(
  .NUM_SENSORS(NUM_SENSORS)
) u_lers_checker (.*);
